/* hw/rtl/wrm_pkg.sv */
`timescale 1ns / 1ps
package wrm_pkg;

    localparam int DATA_W   = 184;
    localparam int LANES    = 7;
    localparam int OP_W     = 32;
    localparam int QUO_BITS = 32;

    localparam logic       FUNC_RESTART      = 1'b1;
    localparam logic [1:0] VALIDITY_UNPARSED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_PREP,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic mul_step;
        logic mul_bit;
        logic div_start;
        logic div_step;
    } lane_ctl_t;

endpackage

/* hw/rtl/weighted_reading_merger_core.sv */
`timescale 1ns / 1ps
// Weighted reading merger: keeps one running record of radiation and GPS
// readings. Each input transfer (restart, ignored reading, or merge) yields
// exactly one output transfer holding the record afterwards. A restart, an
// unparsed reading, or a reading copied into an empty record goes straight
// from the accepting cycle to the output state, which loads the output
// register once it is free. A true merge runs seven averaging lanes side by
// side: bit-serial multiply-accumulate of old value times count and new
// value times weight, then restoring division, with control states between.
// One item is in work at a time; the finished record sits in an output
// register so a new item can be taken while the record waits for its
// consumer.
module weighted_reading_merger_core #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // validity, cpm, cpb, total_count, status_flags, latitude, longitude,
    // altitude, sat_count, precision, weight (lowest bit first), zero fill
    input  logic [wrm_pkg::DATA_W-1:0]  s_tdata,
    // func
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // merged_validity, avg_cpm, avg_cpb, last_total, merged_flags,
    // avg_latitude, avg_longitude, avg_altitude, avg_sats, avg_precision,
    // merge_count (lowest bit first), zero fill
    output logic [wrm_pkg::DATA_W-1:0]  m_tdata
);
    localparam int MW    = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
    localparam int LAST  = (MW > wrm_pkg::QUO_BITS) ? MW : wrm_pkg::QUO_BITS;
    localparam int CNT_W = $clog2(LAST);
    localparam logic [MW:0] CMAX = {(MW+1){1'b1}} >> (MW + 1 - WEIGHT_BITS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MW - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(wrm_pkg::QUO_BITS - 1);

    // input field split
    logic [1:0]  in_val;
    logic [15:0] in_cpm, in_cpb, in_tot, in_wgt;
    logic [1:0]  in_flg;
    logic [30:0] in_lat;
    logic [31:0] in_lon;
    logic [24:0] in_alt;
    logic [6:0]  in_sat;
    logic [13:0] in_prc;

    assign in_val = s_tdata[1:0];
    assign in_cpm = s_tdata[17:2];
    assign in_cpb = s_tdata[33:18];
    assign in_tot = s_tdata[49:34];
    assign in_flg = s_tdata[51:50];
    assign in_lat = s_tdata[82:52];
    assign in_lon = s_tdata[114:83];
    assign in_alt = s_tdata[139:115];
    assign in_sat = s_tdata[146:140];
    assign in_prc = s_tdata[160:147];
    assign in_wgt = s_tdata[176:161];

    wrm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MW-1:0]          mplr_reg, mplr_next;
    logic [MW-1:0]          w_reg, w_next;
    logic [MW:0]            div_reg, div_next;
    logic [WEIGHT_BITS-1:0] count_reg, count_next;
    logic [1:0]             val_reg, val_next;
    logic [15:0]            cpm_reg, cpm_next, cpb_reg, cpb_next, tot_reg, tot_next;
    logic [1:0]             flg_reg, flg_next;
    logic [30:0]            lat_reg, lat_next;
    logic [31:0]            lon_reg, lon_next;
    logic [24:0]            alt_reg, alt_next;
    logic [6:0]             sat_reg, sat_next;
    logic [13:0]            prc_reg, prc_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [wrm_pkg::DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic signed [wrm_pkg::OP_W-1:0] b_reg [wrm_pkg::LANES];
    logic signed [wrm_pkg::OP_W-1:0] b_next [wrm_pkg::LANES];
    logic signed [wrm_pkg::OP_W-1:0] a_val [wrm_pkg::LANES];
    logic signed [wrm_pkg::OP_W-1:0] b_in [wrm_pkg::LANES];
    logic signed [wrm_pkg::OP_W-1:0] q_val [wrm_pkg::LANES];
    wrm_pkg::lane_ctl_t     ctl;
    logic                   in_xfer;
    logic [MW:0]            cnt_ext, w_ext, sum, w_clamp, sum_clamp;

    // lane order: cpm, cpb, latitude, longitude, altitude, sats, precision
    assign a_val[0] = {16'b0, cpm_reg};
    assign a_val[1] = {16'b0, cpb_reg};
    assign a_val[2] = {lat_reg[30], lat_reg};
    assign a_val[3] = lon_reg;
    assign a_val[4] = {{7{alt_reg[24]}}, alt_reg};
    assign a_val[5] = {25'b0, sat_reg};
    assign a_val[6] = {18'b0, prc_reg};

    assign b_in[0] = {16'b0, in_cpm};
    assign b_in[1] = {16'b0, in_cpb};
    assign b_in[2] = {in_lat[30], in_lat};
    assign b_in[3] = in_lon;
    assign b_in[4] = {{7{in_alt[24]}}, in_alt};
    assign b_in[5] = {25'b0, in_sat};
    assign b_in[6] = {18'b0, in_prc};

    for (genvar i = 0; i < wrm_pkg::LANES; i++)
    begin : g_lane
        wrm_lane #(.MW(MW)) u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .a       (a_val[i]),
            .b       (b_reg[i]),
            .divisor (div_reg),
            .q       (q_val[i])
        );
    end

    assign s_tready = (state_reg == wrm_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cnt_ext   = (MW+1)'(count_reg);
    assign w_ext     = (MW+1)'(in_wgt);
    assign sum       = cnt_ext + {1'b0, w_reg};
    assign w_clamp   = (w_ext > CMAX) ? CMAX : w_ext;
    assign sum_clamp = (sum > CMAX) ? CMAX : sum;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mplr_next     = mplr_reg;
        w_next        = w_reg;
        div_next      = div_reg;
        count_next    = count_reg;
        val_next      = val_reg;
        cpm_next      = cpm_reg;
        cpb_next      = cpb_reg;
        tot_next      = tot_reg;
        flg_next      = flg_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        alt_next      = alt_reg;
        sat_next      = sat_reg;
        prc_next      = prc_reg;
        b_next        = b_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctl           = '0;

        case (state_reg)
            wrm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = wrm_pkg::ST_OUT;
                    if (s_tuser == wrm_pkg::FUNC_RESTART)
                    begin
                        // empty the record; other fields stay for reporting
                        count_next = '0;
                    end
                    else if (in_val != wrm_pkg::VALIDITY_UNPARSED)
                    begin
                        if (count_reg == '0)
                        begin
                            // copy the reading whole into the empty record
                            val_next   = in_val;
                            cpm_next   = in_cpm;
                            cpb_next   = in_cpb;
                            tot_next   = in_tot;
                            flg_next   = in_flg;
                            lat_next   = in_lat;
                            lon_next   = in_lon;
                            alt_next   = in_alt;
                            sat_next   = in_sat;
                            prc_next   = in_prc;
                            count_next = w_clamp[WEIGHT_BITS-1:0];
                        end
                        else
                        begin
                            // start the weighted merge
                            val_next   = in_val;
                            tot_next   = in_tot;
                            flg_next   = flg_reg | in_flg;
                            b_next     = b_in;
                            w_next     = MW'(in_wgt);
                            div_next   = cnt_ext + w_ext;
                            mplr_next  = MW'(count_reg);
                            cnt_next   = '0;
                            ctl.load_a = 1'b1;
                            state_next = wrm_pkg::ST_MUL_A;
                        end
                    end
                end
            end
            wrm_pkg::ST_MUL_A:
            begin
                // accumulate old value times count, one count bit per cycle
                ctl.mul_step = 1'b1;
                ctl.mul_bit  = mplr_reg[0];
                mplr_next    = mplr_reg >> 1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST)
                begin
                    ctl.load_b = 1'b1;
                    mplr_next  = w_reg;
                    cnt_next   = '0;
                    state_next = wrm_pkg::ST_MUL_B;
                end
            end
            wrm_pkg::ST_MUL_B:
            begin
                // accumulate new value times weight
                ctl.mul_step = 1'b1;
                ctl.mul_bit  = mplr_reg[0];
                mplr_next    = mplr_reg >> 1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = wrm_pkg::ST_DIV_PREP;
                end
            end
            wrm_pkg::ST_DIV_PREP:
            begin
                ctl.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = wrm_pkg::ST_DIV;
            end
            wrm_pkg::ST_DIV:
            begin
                // one quotient bit per cycle, truncating toward zero
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = wrm_pkg::ST_WRITE;
                end
            end
            wrm_pkg::ST_WRITE:
            begin
                cpm_next   = q_val[0][15:0];
                cpb_next   = q_val[1][15:0];
                lat_next   = q_val[2][30:0];
                lon_next   = q_val[3];
                alt_next   = q_val[4][24:0];
                sat_next   = q_val[5][6:0];
                prc_next   = q_val[6][13:0];
                count_next = sum_clamp[WEIGHT_BITS-1:0];
                state_next = wrm_pkg::ST_OUT;
            end
            wrm_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, 16'(count_reg), prc_reg, sat_reg, alt_reg,
                                     lon_reg, lat_reg, flg_reg, tot_reg, cpb_reg,
                                     cpm_reg, val_reg};
                    state_next    = wrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wrm_pkg::ST_IDLE;
            cnt_reg      <= '0;
            count_reg    <= '0;
            val_reg      <= wrm_pkg::VALIDITY_UNPARSED;
            cpm_reg      <= '0;
            cpb_reg      <= '0;
            tot_reg      <= '0;
            flg_reg      <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            alt_reg      <= '0;
            sat_reg      <= '0;
            prc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            count_reg    <= count_next;
            val_reg      <= val_next;
            cpm_reg      <= cpm_next;
            cpb_reg      <= cpb_next;
            tot_reg      <= tot_next;
            flg_reg      <= flg_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            alt_reg      <= alt_next;
            sat_reg      <= sat_next;
            prc_reg      <= prc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mplr_reg    <= mplr_next;
        w_reg       <= w_next;
        div_reg     <= div_next;
        b_reg       <= b_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

/* hw/rtl/wrm_lane.sv */
`timescale 1ns / 1ps
// One averaging lane: bit-serial signed multiply-accumulate of a*c + b*w,
// then restoring division of the magnitude, one quotient bit per cycle.
module wrm_lane #(
    parameter int MW = 16
) (
    input  logic                     clk,
    input  wrm_pkg::lane_ctl_t       ctl,
    input  logic signed [wrm_pkg::OP_W-1:0] a,
    input  logic signed [wrm_pkg::OP_W-1:0] b,
    input  logic [MW:0]              divisor,
    output logic signed [wrm_pkg::OP_W-1:0] q
);
    localparam int ACC_W = MW + wrm_pkg::OP_W + 2;
    localparam int REM_W = MW + 1;
    localparam int QB    = wrm_pkg::QUO_BITS;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] mcand_reg, mcand_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QB-1:0]    quo_reg, quo_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] mag;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb
    begin
        mag   = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
        trial = {rem_reg, quo_reg[QB-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});

        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;

        if (ctl.load_a)
        begin
            acc_next   = '0;
            mcand_next = {{(ACC_W-wrm_pkg::OP_W){a[wrm_pkg::OP_W-1]}}, a};
        end
        else
        begin
            if (ctl.mul_step && ctl.mul_bit)
            begin
                acc_next = acc_reg + mcand_reg;
            end
            if (ctl.load_b)
            begin
                mcand_next = {{(ACC_W-wrm_pkg::OP_W){b[wrm_pkg::OP_W-1]}}, b};
            end
            else if (ctl.mul_step)
            begin
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
            end
        end

        if (ctl.div_start)
        begin
            neg_next = acc_reg[ACC_W-1];
            rem_next = mag[QB +: REM_W];
            quo_next = mag[QB-1:0];
        end
        else if (ctl.div_step)
        begin
            rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quo_next = {quo_reg[QB-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
    end

    assign q = neg_reg ? (~quo_reg + QB'(1)) : quo_reg;

endmodule

/* hw/rtl/wrm_checker.sv */
`timescale 1ns / 1ps
module wrm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [wrm_pkg::DATA_W-1:0] s_tdata,
    input logic                       s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [wrm_pkg::DATA_W-1:0] m_tdata
);
    // one item in work at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a result never appears in the cycle right after an input transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised too early");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result changed");

    // a restart taken while the output side is free reports an empty record
    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == wrm_pkg::FUNC_RESTART)
            && (!m_tvalid || m_tready)
        |=> ##1 m_tvalid && m_tdata[176:161] == 16'd0)
        else $error("restart did not clear merge count");

endmodule

bind weighted_reading_merger_core wrm_checker u_wrm_checker (.*);
